// File: rtl/psr_pkg.sv
// Shared types and constants for the periodic stencil relaxation core.
// Used by psr_mul, psr_engine and periodic_stencil_relaxation_core.
package psr_pkg;

    // Default geometry and value width
    localparam int SIDE_MAX_DEF   = 64;
    localparam int VALUE_BITS_DEF = 32;

    // Register index codes
    localparam logic [2:0] REG_SIDE   = 3'd0;
    localparam logic [2:0] REG_SWEEPS = 3'd1;
    localparam logic [2:0] REG_SCALE  = 3'd2;
    localparam logic [2:0] REG_HSQ    = 3'd3;
    localparam logic [2:0] REG_METHOD = 3'd4;

    // Register reset values
    localparam logic [6:0]  SIDE_RST   = 7'd64;
    localparam logic [7:0]  SWEEPS_RST = 8'd20;
    localparam logic [15:0] SCALE_RST  = 16'd16384;
    localparam logic [26:0] HSQ_RST    = 27'd65536;
    localparam logic        METHOD_RST = 1'b1;

    // Method codes
    localparam logic METHOD_JACOBI = 1'b0;
    localparam logic METHOD_GS     = 1'b1;

    // Item kinds
    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_READ = 2'd2;

    typedef struct packed {
        logic [6:0]  side_length;
        logic [7:0]  sweep_count;
        logic [15:0] scale_factor;
        logic [26:0] spacing_sq;
        logic        method;
    } cfg_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic [11:0]        cell_index;
        logic signed [31:0] field_in;
        logic signed [31:0] rhs_in;
    } cmd_t;

    typedef struct packed {
        logic signed [31:0] field_out;
        logic               done_res;
    } res_t;

    typedef struct packed {
        logic idle;
        logic res_valid;
    } eng_stat_t;

endpackage

// File: rtl/psr_mul.sv
// Digit-serial signed by unsigned multiplier, returns floor(a * b / 2^16).
// One 16-bit digit of a per cycle, top digit first. Uses psr_pkg.
module psr_mul #(
    parameter int A_W = 44
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic signed [A_W-1:0]      a,
    input  logic [26:0]                b,
    output logic                       done,
    output logic signed [((A_W+15)/16)*16+11:0] prod_q
);
    import psr_pkg::*;

    localparam int ND  = (A_W + 15) / 16;
    localparam int EW  = ND * 16;
    localparam int PW  = EW + 28;
    localparam int CW  = (ND > 1) ? $clog2(ND) : 1;

    logic [EW-1:0]        a_reg;
    logic [26:0]          b_reg;
    logic signed [PW-1:0] acc_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [15:0]          digit;
    logic [16:0]          d17;
    logic signed [44:0]   pp;

    // Partial product of the current digit; only the top digit carries sign
    always_comb begin
        digit = a_reg[EW-1 -: 16];
        d17   = (cnt_reg == '0) ? {digit[15], digit} : {1'b0, digit};
        pp    = $signed(d17) * $signed({1'b0, b_reg});
    end

    // Accumulate Horner style and flag completion
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= EW'(a);
                b_reg    <= b;
                acc_reg  <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                acc_reg <= (acc_reg <<< 16) + PW'(pp);
                a_reg   <= a_reg << 16;
                if (cnt_reg == CW'(ND - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
        end
    end

    assign done   = done_reg;
    assign prod_q = acc_reg[PW-1:16];

endmodule

// File: rtl/psr_engine.sv
// Memory-centered relaxation sequencer: field, rhs and Jacobi memories,
// neighbour read sequencing, serial multiply, write back and copy pass.
// Uses psr_pkg and psr_mul.
module psr_engine #(
    parameter int SIDE_MAX   = psr_pkg::SIDE_MAX_DEF,
    parameter int VALUE_BITS = psr_pkg::VALUE_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  psr_pkg::cfg_t     cfg,
    input  logic              start,
    input  psr_pkg::cmd_t     cmd,
    input  logic              res_ready,
    output psr_pkg::eng_stat_t stat,
    output psr_pkg::res_t     res
);
    import psr_pkg::*;

    localparam int VB    = VALUE_BITS;
    localparam int DEPTH = SIDE_MAX * SIDE_MAX;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(SIDE_MAX + 1);
    localparam int SW    = VB + 2;
    localparam int PWD   = VB + 11;
    localparam int DW    = VB + 12;
    localparam int ND    = (DW + 15) / 16;
    localparam int RW    = ND * 16 + 12;

    localparam logic signed [63:0] TOP64 = (64'sd1 <<< (VB - 1)) - 64'sd1;
    localparam logic signed [63:0] BOT64 = -TOP64 - 64'sd1;
    localparam logic signed [RW-1:0] TOPR = RW'(TOP64);
    localparam logic signed [RW-1:0] BOTR = RW'(BOT64);

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD_WAIT, ST_SETUP, ST_NB_RD, ST_NB_LAST,
        ST_WAIT_P, ST_WAIT_S, ST_COPY, ST_COPY_END, ST_DONE
    } state_t;

    state_t state_reg;

    // Memories
    logic [VB-1:0] fld_mem [DEPTH];
    logic [VB-1:0] rhs_mem [DEPTH];
    logic [VB-1:0] jac_mem [DEPTH];
    logic [VB-1:0] fld_rd, rhs_rd, jac_rd;

    logic          fld_we, rhs_we, jac_we;
    logic [AW-1:0] fld_wa, fld_ra, rhs_ra, jac_ra;
    logic [VB-1:0] fld_wd, rhs_wd, jac_wd;

    // Run registers
    logic [NW-1:0]        n_reg, x_reg, y_reg;
    logic [AW-1:0]        addr_reg, nn1_reg;
    logic [1:0]           k_reg;
    logic [7:0]           sweep_reg;
    logic signed [SW-1:0] sum_reg;
    logic                 acc_en_reg;
    logic [AW:0]          cnt_reg;
    logic [AW-1:0]        cp_a_reg;
    logic                 cp_v_reg;
    logic signed [31:0]   res_field_reg;
    logic                 res_done_reg;

    // Multiplier hookup
    logic                 mul_start, mul_done;
    logic signed [DW-1:0] mul_a;
    logic [26:0]          mul_b;
    logic signed [RW-1:0] mres;

    // Combinational helpers
    logic                 idx_ok;
    logic [AW-1:0]        idx_a;
    logic signed [63:0]   fin64, rin64;
    logic [VB-1:0]        fin_sat, rin_sat;
    logic [NW-1:0]        n_calc;
    logic [AW-1:0]        nm1_a, n_a, nb_addr;
    logic signed [PWD-1:0] p_val;
    logic [VB-1:0]        new_val;
    logic                 cell_wr, last_x, last_y;
    logic [AW:0]          nsq;
    logic signed [63:0]   rd64;

    always_comb begin
        idx_ok  = (32'(cmd.cell_index) < DEPTH);
        idx_a   = AW'(cmd.cell_index);
        fin64   = 64'(cmd.field_in);
        rin64   = 64'(cmd.rhs_in);
        fin_sat = (fin64 > TOP64) ? VB'(TOP64) : (fin64 < BOT64) ? VB'(BOT64) : VB'(fin64);
        rin_sat = (rin64 > TOP64) ? VB'(TOP64) : (rin64 < BOT64) ? VB'(BOT64) : VB'(rin64);
        if (cfg.side_length == '0) begin
            n_calc = NW'(1);
        end else if (32'(cfg.side_length) > SIDE_MAX) begin
            n_calc = NW'(SIDE_MAX);
        end else begin
            n_calc = NW'(cfg.side_length);
        end
        nm1_a  = AW'(n_reg) - AW'(1);
        n_a    = AW'(n_reg);
        last_x = (x_reg == n_reg - NW'(1));
        last_y = (y_reg == n_reg - NW'(1));
        nsq    = (AW+1)'(nn1_reg) + (AW+1)'(n_reg);
        rd64   = 64'($signed(fld_rd));
        // Wrapped neighbour address: east, west, north, south
        case (k_reg)
            2'd0:    nb_addr = last_x ? addr_reg - nm1_a : addr_reg + AW'(1);
            2'd1:    nb_addr = (x_reg == '0) ? addr_reg + nm1_a : addr_reg - AW'(1);
            2'd2:    nb_addr = last_y ? addr_reg - nn1_reg : addr_reg + n_a;
            default: nb_addr = (y_reg == '0) ? addr_reg + nn1_reg : addr_reg - n_a;
        endcase
        p_val   = $signed(mres[PWD-1:0]);
        new_val = (mres > TOPR) ? VB'(TOP64) : (mres < BOTR) ? VB'(BOT64) : VB'(mres);
        cell_wr = (state_reg == ST_WAIT_S) && mul_done;
    end

    // Multiplier operands: rhs times spacing, then difference times scale
    always_comb begin
        mul_start = (state_reg == ST_NB_LAST) || ((state_reg == ST_WAIT_P) && mul_done);
        if (state_reg == ST_NB_LAST) begin
            mul_a = DW'($signed(rhs_rd));
            mul_b = cfg.spacing_sq;
        end else begin
            mul_a = DW'(sum_reg) - DW'(p_val);
            mul_b = 27'(cfg.scale_factor);
        end
    end

    psr_mul #(.A_W(DW)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .prod_q  (mres)
    );

    // Memory port selection
    always_comb begin
        fld_we = 1'b0;
        fld_wa = cp_a_reg;
        fld_wd = jac_rd;
        if (state_reg == ST_IDLE && start && cmd.mode == MODE_LOAD && idx_ok) begin
            fld_we = 1'b1;
            fld_wa = idx_a;
            fld_wd = fin_sat;
        end else if (cell_wr && cfg.method == METHOD_GS) begin
            fld_we = 1'b1;
            fld_wa = addr_reg;
            fld_wd = new_val;
        end else if (cp_v_reg) begin
            fld_we = 1'b1;
        end
        fld_ra = (state_reg == ST_IDLE) ? idx_a : nb_addr;
        rhs_we = (state_reg == ST_IDLE) && start && (cmd.mode == MODE_LOAD) && idx_ok;
        rhs_wd = rin_sat;
        rhs_ra = (state_reg == ST_IDLE) ? idx_a : addr_reg;
        jac_we = cell_wr && (cfg.method == METHOD_JACOBI);
        jac_wd = new_val;
        jac_ra = cnt_reg[AW-1:0];
    end

    // Field store
    always_ff @(posedge aclk) begin
        if (fld_we) begin
            fld_mem[fld_wa] <= fld_wd;
        end
        fld_rd <= fld_mem[fld_ra];
    end

    // Right-hand side store
    always_ff @(posedge aclk) begin
        if (rhs_we) begin
            rhs_mem[idx_a] <= rhs_wd;
        end
        rhs_rd <= rhs_mem[rhs_ra];
    end

    // Jacobi scratch store
    always_ff @(posedge aclk) begin
        if (jac_we) begin
            jac_mem[addr_reg] <= jac_wd;
        end
        jac_rd <= jac_mem[jac_ra];
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            acc_en_reg   <= 1'b0;
            cp_v_reg     <= 1'b0;
            res_done_reg <= 1'b0;
        end else begin
            acc_en_reg <= (state_reg == ST_NB_RD);
            cp_v_reg   <= (state_reg == ST_COPY);
            if (state_reg == ST_NB_RD && k_reg == 2'd0) begin
                sum_reg <= '0;
            end else if (acc_en_reg) begin
                sum_reg <= sum_reg + SW'($signed(fld_rd));
            end
            case (state_reg)
                ST_IDLE: begin
                    if (start) begin
                        res_field_reg <= '0;
                        res_done_reg  <= 1'b0;
                        n_reg         <= n_calc;
                        case (cmd.mode)
                            MODE_LOAD: begin
                                res_done_reg <= idx_ok;
                                state_reg    <= ST_DONE;
                            end
                            MODE_RUN: begin
                                res_done_reg <= 1'b1;
                                state_reg    <= (cfg.sweep_count == '0) ? ST_DONE : ST_SETUP;
                            end
                            MODE_READ: begin
                                state_reg <= idx_ok ? ST_RD_WAIT : ST_DONE;
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_RD_WAIT: begin
                    res_field_reg <= rd64[31:0];
                    res_done_reg  <= 1'b1;
                    state_reg     <= ST_DONE;
                end
                ST_SETUP: begin
                    nn1_reg   <= AW'(int'(n_reg - NW'(1)) * int'(n_reg));
                    x_reg     <= '0;
                    y_reg     <= '0;
                    addr_reg  <= '0;
                    k_reg     <= '0;
                    sweep_reg <= '0;
                    state_reg <= ST_NB_RD;
                end
                ST_NB_RD: begin
                    // issue one neighbour read per cycle
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd3) begin
                        state_reg <= ST_NB_LAST;
                    end
                end
                ST_NB_LAST: begin
                    state_reg <= ST_WAIT_P;
                end
                ST_WAIT_P: begin
                    if (mul_done) begin
                        state_reg <= ST_WAIT_S;
                    end
                end
                ST_WAIT_S: begin
                    if (mul_done) begin
                        // advance y inner, x outer
                        k_reg <= '0;
                        if (last_y) begin
                            y_reg <= '0;
                            if (last_x) begin
                                x_reg    <= '0;
                                addr_reg <= '0;
                                if (cfg.method == METHOD_JACOBI) begin
                                    cnt_reg   <= '0;
                                    state_reg <= ST_COPY;
                                end else begin
                                    sweep_reg <= sweep_reg + 8'd1;
                                    state_reg <= (sweep_reg + 8'd1 == cfg.sweep_count)
                                                 ? ST_DONE : ST_NB_RD;
                                end
                            end else begin
                                x_reg    <= x_reg + NW'(1);
                                addr_reg <= AW'(x_reg) + AW'(1);
                                state_reg <= ST_NB_RD;
                            end
                        end else begin
                            y_reg     <= y_reg + NW'(1);
                            addr_reg  <= addr_reg + n_a;
                            state_reg <= ST_NB_RD;
                        end
                    end
                end
                ST_COPY: begin
                    // read scratch, write field in the next cycle
                    cp_a_reg <= cnt_reg[AW-1:0];
                    cnt_reg  <= cnt_reg + (AW+1)'(1);
                    if (cnt_reg == nsq - (AW+1)'(1)) begin
                        state_reg <= ST_COPY_END;
                    end
                end
                ST_COPY_END: begin
                    sweep_reg <= sweep_reg + 8'd1;
                    state_reg <= (sweep_reg + 8'd1 == cfg.sweep_count) ? ST_DONE : ST_NB_RD;
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign stat.idle      = (state_reg == ST_IDLE);
    assign stat.res_valid = (state_reg == ST_DONE);
    assign res.field_out  = res_field_reg;
    assign res.done_res   = res_done_reg;

endmodule

// File: rtl/periodic_stencil_relaxation_core.sv
// Periodic 5-point relaxation core. A load word writes the cell and finishes; a read word
// waits on the registered field memory read. A run item reads the four neighbours of each
// cell, then does two serial multiplies of ND = ceil((VALUE_BITS+12)/16) digits each,
// plus a copy pass after each Jacobi sweep. One item in flight; the next input word is
// taken while a result waits. Synchronous active-low reset clears control and loads
// register defaults; the memories are not cleared. Uses psr_pkg and psr_engine.
module periodic_stencil_relaxation_core #(
    parameter int SIDE_MAX   = psr_pkg::SIDE_MAX_DEF,
    parameter int VALUE_BITS = psr_pkg::VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [26:0] cfg_data,
    // input channel
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // cell_index[11:0], field_in[43:12], rhs_in[75:44]
    input  logic [1:0]  s_axis_tuser,  // mode[1:0]
    // result channel
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // field_out[31:0]
    output logic [0:0]  m_axis_tuser   // done_res[0]
);
    import psr_pkg::*;

    cfg_t      cfg_reg;
    cmd_t      cmd;
    res_t      res;
    eng_stat_t eng_stat;
    logic      res_ready;
    logic      m_valid_reg;
    res_t      m_res_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.side_length  <= SIDE_RST;
            cfg_reg.sweep_count  <= SWEEPS_RST;
            cfg_reg.scale_factor <= SCALE_RST;
            cfg_reg.spacing_sq   <= HSQ_RST;
            cfg_reg.method       <= METHOD_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_SIDE:   cfg_reg.side_length  <= cfg_data[6:0];
                REG_SWEEPS: cfg_reg.sweep_count  <= cfg_data[7:0];
                REG_SCALE:  cfg_reg.scale_factor <= cfg_data[15:0];
                REG_HSQ:    cfg_reg.spacing_sq   <= cfg_data;
                REG_METHOD: cfg_reg.method       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Unpack the input word
    always_comb begin
        cmd.mode       = s_axis_tuser;
        cmd.cell_index = s_axis_tdata[11:0];
        cmd.field_in   = $signed(s_axis_tdata[43:12]);
        cmd.rhs_in     = $signed(s_axis_tdata[75:44]);
    end

    assign s_axis_tready = eng_stat.idle;
    assign res_ready     = !m_valid_reg || m_axis_tready;

    psr_engine #(
        .SIDE_MAX   (SIDE_MAX),
        .VALUE_BITS (VALUE_BITS)
    ) u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .start     (s_axis_tvalid && s_axis_tready),
        .cmd       (cmd),
        .res_ready (res_ready),
        .stat      (eng_stat),
        .res       (res)
    );

    // Output register: load a finished result, drop it when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (eng_stat.res_valid && res_ready) begin
            m_valid_reg <= 1'b1;
            m_res_reg   <= res;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_res_reg.field_out;
    assign m_axis_tuser[0] = m_res_reg.done_res;

    a_busy_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        eng_stat.res_valid |-> !s_axis_tready)
        else $error("input taken while a result is pending in the engine");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) |=> !eng_stat.idle)
        else $error("engine stayed idle after taking an input word");

    a_result_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        (eng_stat.res_valid && res_ready) |=> m_axis_tvalid)
        else $error("handed-off result missing from output register");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for periodic_stencil_relaxation_core.
// Drives load, run and read words and checks each result against an in-bench
// lattice relaxation predictor. Depends on psr_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;
    import psr_pkg::*;

    localparam int CELLS = SIDE_MAX_DEF * SIDE_MAX_DEF;

    typedef struct {
        logic [1:0]  mode;
        logic [11:0] cell_index;
        logic [31:0] field_in;
        logic [31:0] rhs_in;
    } lattice_op_t;

    typedef struct {
        logic [31:0] field_out;
        logic        done_res;
    } lattice_ans_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [26:0] cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;

    periodic_stencil_relaxation_core dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // Predictor state: lattice stores and register copies
    longint      lat_field [CELLS];
    longint      lat_rhs   [CELLS];
    longint      lat_next  [CELLS];
    bit          cell_loaded [CELLS];
    int          loaded_list [$];
    logic [6:0]  cur_side;
    logic [7:0]  cur_sweeps;
    logic [15:0] cur_scale;
    logic [26:0] cur_hsq;
    logic        cur_method;

    lattice_op_t  op_queue [$];
    lattice_ans_t answer_queue [$];
    lattice_op_t  op_on_bus;
    int           send_idle_pct;
    int           recv_idle_pct;
    int           mismatches;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // floor(a * b / 2^16); products stay well inside 64 bits
    function automatic longint q16_mul(longint a, longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic longint relax_cell(int x, int y, int n);
        longint sum;
        longint diff;
        sum = lat_field[(x + 1) % n + y * n] + lat_field[(x + n - 1) % n + y * n]
            + lat_field[x + ((y + 1) % n) * n] + lat_field[x + ((y + n - 1) % n) * n];
        diff = sum - q16_mul(lat_rhs[x + y * n], longint'(cur_hsq));
        return sat32(q16_mul(diff, longint'(cur_scale)));
    endfunction

    task automatic relax_lattice();
        int n;
        n = (cur_side == 0) ? 1 : ((cur_side > SIDE_MAX_DEF) ? SIDE_MAX_DEF : cur_side);
        for (int s = 0; s < cur_sweeps; s++) begin
            for (int x = 0; x < n; x++)
                for (int y = 0; y < n; y++)
                    if (cur_method == METHOD_GS) lat_field[x + y * n] = relax_cell(x, y, n);
                    else lat_next[x + y * n] = relax_cell(x, y, n);
            if (cur_method == METHOD_JACOBI)
                for (int i = 0; i < n * n; i++) lat_field[i] = lat_next[i];
        end
    endtask

    // Work out the answer of one accepted word and update the lattice
    task automatic predict_op(lattice_op_t op);
        lattice_ans_t ans;
        ans.field_out = '0;
        ans.done_res = 1'b0;
        case (op.mode)
            MODE_LOAD: begin
                lat_field[op.cell_index] = longint'(signed'(op.field_in));
                lat_rhs[op.cell_index] = longint'(signed'(op.rhs_in));
                ans.done_res = 1'b1;
            end
            MODE_RUN: begin
                relax_lattice();
                ans.done_res = 1'b1;
            end
            MODE_READ: begin
                ans.field_out = lat_field[op.cell_index][31:0];
                ans.done_res = 1'b1;
            end
            default: ;
        endcase
        answer_queue.push_back(ans);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch %s: got %h expected %h", $time, what, got, want);
        mismatches++;
    endtask

    // Driver: when the bus is free, present the next word unless a random idle is drawn
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) predict_op(op_on_bus);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (op_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    op_on_bus = op_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser <= op_on_bus.mode;
                    s_axis_tdata <= {4'b0, op_on_bus.rhs_in, op_on_bus.field_in,
                                     op_on_bus.cell_index};
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: stall at random and check each result word in order
    always @(posedge aclk) begin
        lattice_ans_t want;
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (answer_queue.size() == 0) begin
                    report_mismatch("unexpected word", m_axis_tdata, 32'h0);
                end else begin
                    want = answer_queue.pop_front();
                    if (m_axis_tdata !== want.field_out)
                        report_mismatch("field_out", m_axis_tdata, want.field_out);
                    if (m_axis_tuser[0] !== want.done_res)
                        report_mismatch("done_res", 32'(m_axis_tuser), 32'(want.done_res));
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [26:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_SIDE:   cur_side = val[6:0];
            REG_SWEEPS: cur_sweeps = val[7:0];
            REG_SCALE:  cur_scale = val[15:0];
            REG_HSQ:    cur_hsq = val;
            REG_METHOD: cur_method = val[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (op_queue.size() > 0 || answer_queue.size() > 0 || s_axis_tvalid)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic configure(int side, int sweeps, int scale, int hsq, bit meth);
        wait_drained();
        write_reg(REG_SIDE, 27'(side));
        write_reg(REG_SWEEPS, 27'(sweeps));
        write_reg(REG_SCALE, 27'(scale));
        write_reg(REG_HSQ, 27'(hsq));
        write_reg(REG_METHOD, 27'(meth));
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(5))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
        endcase
    endfunction

    function automatic void queue_op(logic [1:0] m, int idx, logic [31:0] f, logic [31:0] r);
        lattice_op_t op;
        op.mode = m;
        op.cell_index = 12'(idx);
        op.field_in = f;
        op.rhs_in = r;
        op_queue.push_back(op);
        if (m == MODE_LOAD && !cell_loaded[idx]) begin
            cell_loaded[idx] = 1'b1;
            loaded_list.push_back(idx);
        end
    endfunction

    // Load every cell of the active lattice, a random mix of words, then a run and a read of every cell
    task automatic random_phase(int nops);
        int n;
        int roll;
        n = (cur_side == 0) ? 1 : ((cur_side > SIDE_MAX_DEF) ? SIDE_MAX_DEF : cur_side);
        for (int i = 0; i < n * n; i++) queue_op(MODE_LOAD, i, pick_value(), pick_value());
        for (int k = 0; k < nops; k++) begin
            roll = $urandom_range(99);
            if (roll < 50)
                queue_op(MODE_READ, loaded_list[$urandom_range(loaded_list.size() - 1)],
                         $urandom, $urandom);
            else if (roll < 82)
                queue_op(MODE_LOAD, $urandom_range(CELLS - 1), pick_value(), pick_value());
            else if (roll < 88)
                queue_op(MODE_RUN, $urandom_range(CELLS - 1), $urandom, $urandom);
            else if (roll < 94)
                queue_op(MODE_LOAD, $urandom_range(n * n - 1), pick_value(), pick_value());
            else
                queue_op(2'd3, $urandom_range(CELLS - 1), $urandom, $urandom);
        end
        queue_op(MODE_RUN, 0, 32'h0, 32'h0);
        for (int i = 0; i < n * n; i++) queue_op(MODE_READ, i, 32'h0, 32'h0);
    endtask

    // Stimulus and configuration sequence
    initial begin
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        mismatches = 0;
        send_idle_pct = 8;
        recv_idle_pct = 51;
        cur_side = SIDE_RST;
        cur_sweeps = SWEEPS_RST;
        cur_scale = SCALE_RST;
        cur_hsq = HSQ_RST;
        cur_method = METHOD_RST;
        for (int i = 0; i < CELLS; i++) begin
            lat_field[i] = 0;
            lat_rhs[i] = 0;
            lat_next[i] = 0;
        end
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes on a 2x2 torus, edge addresses, unused mode
        configure(2, 1, 65535, 67108864, METHOD_GS);
        queue_op(MODE_LOAD, 0, 32'h7fffffff, 32'h80000000);
        queue_op(MODE_LOAD, 1, 32'h80000000, 32'h7fffffff);
        queue_op(MODE_LOAD, 2, 32'h7fffffff, 32'h7fffffff);
        queue_op(MODE_LOAD, 3, 32'h00000000, 32'hffffffff);
        queue_op(MODE_LOAD, 4095, 32'h12345678, 32'hfedcba98);
        queue_op(MODE_READ, 4095, 32'hffffffff, 32'hffffffff);
        queue_op(2'd3, 4095, 32'hffffffff, 32'hffffffff);
        queue_op(MODE_RUN, 0, 32'h0, 32'h0);
        for (int i = 0; i < 4; i++) queue_op(MODE_READ, i, 32'h0, 32'h0);
        configure(2, 255, 0, 0, METHOD_JACOBI);
        queue_op(MODE_RUN, 0, 32'h0, 32'h0);
        queue_op(MODE_READ, 0, 32'h0, 32'h0);
        // zero sweeps and a zero side that acts as one cell
        configure(0, 0, 16384, 65536, METHOD_GS);
        queue_op(MODE_RUN, 0, 32'h0, 32'h0);
        queue_op(MODE_READ, 1, 32'h0, 32'h0);
        configure(0, 3, 40000, 131072, METHOD_JACOBI);
        queue_op(MODE_RUN, 0, 32'h0, 32'h0);
        queue_op(MODE_READ, 0, 32'h0, 32'h0);

        // Random phases across idle profiles
        for (int p = 0; p < 9; p++) begin
            if (p == 3) begin
                send_idle_pct = 51;
                recv_idle_pct = 8;
            end else if (p == 6) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            configure($urandom_range(2, 8), $urandom_range(1, 5), $urandom_range(65535),
                      $urandom_range(67108864), (p % 2) == 1);
            random_phase(90);
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Run limit
    initial begin
        #50ms;
        $display("== FAIL ==");
        $finish;
    end
endmodule

// File: files.f
rtl/psr_pkg.sv
rtl/psr_mul.sv
rtl/psr_engine.sv
rtl/periodic_stencil_relaxation_core.sv
tb/testbench.sv
